[hw/rtl/lld_pkg.sv]
// shared types, constants and codes for the least-loaded dispatcher
`default_nettype none

package lld_pkg;

    // field widths
    localparam int CFG_W    = 5;
    localparam int WORKER_W = 4;
    localparam int LOAD_W   = 16;
    localparam int STATUS_W = 2;

    // default configuration
    localparam int          MAX_WORKERS_DEFAULT = 16;
    localparam logic [CFG_W-1:0] NUM_WORKERS_RESET = 5'd16;

    // count limits
    localparam logic signed [LOAD_W-1:0] LOAD_MAX = 16'sh7FFF;
    localparam logic signed [LOAD_W-1:0] LOAD_MIN = 16'sh8000;

    // command codes
    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_DONE   = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef logic signed [LOAD_W-1:0] load_t;

    typedef struct packed {
        logic                cmd;
        logic [WORKER_W-1:0] worker;
    } req_t;

    typedef struct packed {
        logic [WORKER_W-1:0] chosen_worker;
        load_t               load_after;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // shared unit operations
    typedef enum logic [1:0] {
        ALU_CMP,
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    typedef struct packed {
        logic  le;
        load_t value;
        logic  sat;
    } alu_res_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DREAD,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/lld_load_ram.sv]
// per-worker count memory with registered read and valid bits cleared at reset
`default_nettype none

module lld_load_ram #(
    parameter int DEPTH = lld_pkg::MAX_WORKERS_DEFAULT,
    parameter int IDX_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             re,
    input  wire logic [IDX_W-1:0] raddr,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire lld_pkg::load_t   wdata,
    output lld_pkg::load_t        rdata
);

    lld_pkg::load_t   mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    lld_pkg::load_t   rdata_reg;
    logic             rvalid_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // valid bits, an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

[hw/rtl/lld_alu.sv]
// shared compare and saturating increment/decrement unit
`default_nettype none

module lld_alu (
    input  wire lld_pkg::alu_op_t op,
    input  wire lld_pkg::load_t   a,
    input  wire lld_pkg::load_t   b,
    output lld_pkg::alu_res_t     res
);

    always_comb
    begin
        res.le    = (a <= b);
        res.value = a;
        res.sat   = 1'b0;
        case (op)
            lld_pkg::ALU_CMP:
            begin
                res.value = a;
            end
            lld_pkg::ALU_INC:
            begin
                if (a == lld_pkg::LOAD_MAX)
                begin
                    res.sat = 1'b1;
                end
                else
                begin
                    res.value = a + 16'sd1;
                end
            end
            lld_pkg::ALU_DEC:
            begin
                if (a == lld_pkg::LOAD_MIN)
                begin
                    res.sat = 1'b1;
                end
                else
                begin
                    res.value = a - 16'sd1;
                end
            end
            default:
            begin
                res.value = a;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/least_loaded_dispatcher.sv]
// top level: sequencer, configuration register and result register
// Least-loaded dispatcher. Requests arrive on req (valid/ready) and each one
// produces exactly one item on rsp (valid/ready). An assign request scans the
// counts of workers 0..n-1, one count per cycle through the single read port
// of the count memory and the shared compare unit, picks the smallest (ties go
// to the highest index), increments it and returns index and new count.
// A done request reads, decrements and returns the named worker's count.
// An assign passes through the scan, update and finish states; a done
// passes through the read-and-decrement and finish states, and a done with an
// index out of range goes straight to finish. n is the effective worker
// count (num_workers, 0 taken as 1, capped at MAX_WORKERS). The sequencer
// returns to idle as the result is registered and takes the next request there.
// One request is in work at a time; req_ready is high only while the
// sequencer is idle.
// The result sits in an output register; the next request is accepted while
// it waits, and a finished result waits for the register to free up when
// the receiver stalls. Counts saturate at the signed 16-bit limits.
// Reset sets num_workers to 16 and clears all counts at once through
// per-entry valid bits; no clearing pass is needed.
// cfg_we writes num_workers from cfg_wdata; write it only while idle.
`default_nettype none

module least_loaded_dispatcher #(
    parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire lld_pkg::req_t             req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output lld_pkg::rsp_t                  rsp,
    input  wire logic                      cfg_we,
    input  wire logic [lld_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);
    localparam int EW    = (CNT_W > lld_pkg::CFG_W) ? CNT_W : lld_pkg::CFG_W;

    lld_pkg::state_t             state_reg, state_next;
    logic [lld_pkg::CFG_W-1:0]   num_workers_reg;
    logic [EW-1:0]               idx_reg, idx_next;
    logic [IDX_W-1:0]            tag_reg, tag_next;
    logic [IDX_W-1:0]            pick_reg, pick_next;
    lld_pkg::load_t              best_reg, best_next;
    logic [lld_pkg::WORKER_W-1:0] worker_reg, worker_next;
    lld_pkg::rsp_t               res_reg, res_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    lld_pkg::rsp_t               rsp_reg, rsp_next;

    logic [EW-1:0]    num_ext;
    logic [EW-1:0]    n_eff;
    logic [EW-1:0]    worker_ext;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    lld_pkg::load_t   ram_wdata;
    lld_pkg::load_t   ram_rdata;
    lld_pkg::alu_op_t alu_op;
    lld_pkg::load_t   alu_a;
    lld_pkg::load_t   alu_b;
    lld_pkg::alu_res_t alu_res;
    logic             out_free;

    // effective worker count
    assign num_ext    = EW'(num_workers_reg);
    assign n_eff      = (num_ext == '0) ? EW'(1) :
                        (num_ext > EW'(MAX_WORKERS)) ? EW'(MAX_WORKERS) : num_ext;
    assign worker_ext = EW'(req.worker);
    assign out_free   = !rsp_valid_reg || rsp_ready;

    lld_load_ram #(
        .DEPTH (MAX_WORKERS),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (ram_re),
        .raddr (ram_raddr),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    lld_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lld_pkg::ST_IDLE;
            num_workers_reg <= lld_pkg::NUM_WORKERS_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                num_workers_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        tag_reg    <= tag_next;
        pick_reg   <= pick_next;
        best_reg   <= best_next;
        worker_reg <= worker_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        tag_next       = tag_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        worker_next    = worker_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        req_ready      = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        ram_we         = 1'b0;
        ram_waddr      = pick_reg;
        ram_wdata      = alu_res.value;
        alu_op         = lld_pkg::ALU_CMP;
        alu_a          = ram_rdata;
        alu_b          = best_reg;

        case (state_reg)
            lld_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    worker_next = req.worker;
                    if (req.cmd == lld_pkg::CMD_ASSIGN)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        tag_next   = '0;
                        idx_next   = EW'(1);
                        state_next = lld_pkg::ST_SCAN;
                    end
                    else if (worker_ext < n_eff)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = worker_ext[IDX_W-1:0];
                        state_next = lld_pkg::ST_DREAD;
                    end
                    else
                    begin
                        res_next.chosen_worker = req.worker;
                        res_next.load_after    = '0;
                        res_next.status        = lld_pkg::STATUS_RANGE;
                        state_next             = lld_pkg::ST_FINISH;
                    end
                end
            end

            // compare the count that arrived, issue the next read
            lld_pkg::ST_SCAN:
            begin
                alu_op = lld_pkg::ALU_CMP;
                if ((tag_reg == '0) || alu_res.le)
                begin
                    best_next = ram_rdata;
                    pick_next = tag_reg;
                end
                if (idx_reg < n_eff)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg[IDX_W-1:0];
                    tag_next  = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + EW'(1);
                end
                else
                begin
                    state_next = lld_pkg::ST_UPDATE;
                end
            end

            // increment the chosen count
            lld_pkg::ST_UPDATE:
            begin
                alu_op    = lld_pkg::ALU_INC;
                alu_a     = best_reg;
                ram_we    = 1'b1;
                ram_waddr = pick_reg;
                res_next.chosen_worker = lld_pkg::WORKER_W'(pick_reg);
                res_next.load_after    = alu_res.value;
                res_next.status        = alu_res.sat ? lld_pkg::STATUS_SAT
                                                     : lld_pkg::STATUS_OK;
                state_next = lld_pkg::ST_FINISH;
            end

            // decrement the named count
            lld_pkg::ST_DREAD:
            begin
                alu_op    = lld_pkg::ALU_DEC;
                alu_a     = ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(worker_reg);
                res_next.chosen_worker = worker_reg;
                res_next.load_after    = alu_res.value;
                res_next.status        = alu_res.sat ? lld_pkg::STATUS_SAT
                                                     : lld_pkg::STATUS_OK;
                state_next = lld_pkg::ST_FINISH;
            end

            // hand the result to the output register
            lld_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = lld_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lld_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[bench/lld_tb_pkg.sv]
// load-tracking scoreboard for the least-loaded dispatcher testbench
`timescale 1ns / 1ps

package lld_tb_pkg;

    import lld_pkg::*;

    localparam int WORKERS    = MAX_WORKERS_DEFAULT;
    localparam int REPORT_CAP = 40;

    class load_tracker;
        load_t            worker_load [WORKERS];
        logic [CFG_W-1:0] num_workers;
        rsp_t             expected_rsp [$];
        int               errors;

        function new();
            num_workers = NUM_WORKERS_RESET;
            foreach (worker_load[i])
                worker_load[i] = '0;
            errors = 0;
        endfunction

        function void set_workers(logic [CFG_W-1:0] value);
            num_workers = value;
        endfunction

        // zero acts as one, anything above the array size is clipped
        function int active_workers();
            int n;
            n = int'(num_workers);
            if (n == 0)
                n = 1;
            if (n > WORKERS)
                n = WORKERS;
            return n;
        endfunction

        function int pending_count();
            return expected_rsp.size();
        endfunction

        // work out the response to one accepted item and update the counts
        function void note_request(req_t item);
            int   n;
            int   pick;
            int   w;
            rsp_t want;
            n = active_workers();
            w = int'(item.worker);
            want = '0;
            want.status = STATUS_OK;
            if (item.cmd == CMD_ASSIGN)
            begin
                // smallest count wins, ties go to the higher index
                pick = 0;
                for (int i = 1; i < n; i++)
                    if (worker_load[i] <= worker_load[pick])
                        pick = i;
                if (worker_load[pick] == LOAD_MAX)
                    want.status = STATUS_SAT;
                else
                    worker_load[pick] = worker_load[pick] + 16'sd1;
                want.chosen_worker = WORKER_W'(pick);
                want.load_after    = worker_load[pick];
            end
            else if (w >= n)
            begin
                // done for a worker outside the selection is dropped
                want.chosen_worker = item.worker;
                want.load_after    = '0;
                want.status        = STATUS_RANGE;
            end
            else
            begin
                if (worker_load[w] == LOAD_MIN)
                    want.status = STATUS_SAT;
                else
                    worker_load[w] = worker_load[w] - 16'sd1;
                want.chosen_worker = item.worker;
                want.load_after    = worker_load[w];
            end
            expected_rsp = {expected_rsp, want};
        endfunction

        task report_mismatch(string what, int got, int want);
            if (errors < REPORT_CAP)
                $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            errors++;
        endtask

        // compare one accepted response with the oldest prediction
        task check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("response with nothing pending", int'(got.chosen_worker), -1);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (got.chosen_worker !== want.chosen_worker)
                    report_mismatch("chosen_worker", int'(got.chosen_worker),
                                    int'(want.chosen_worker));
                if (got.load_after !== want.load_after)
                    report_mismatch("load_after", int'(got.load_after), int'(want.load_after));
                if (got.status !== want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
            end
        endtask

        task check_leftover();
            if (expected_rsp.size() != 0)
                report_mismatch("responses never seen", expected_rsp.size(), 0);
        endtask
    endclass

endpackage

[bench/tb_least_loaded_dispatcher.sv]
// top-level testbench for the least-loaded dispatcher
`timescale 1ns / 1ps

module tb_least_loaded_dispatcher;

    import lld_pkg::*;
    import lld_tb_pkg::*;

    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2500000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    req_t             req       = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    rsp_t             rsp;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    load_tracker tracker = new();

    int cycle_count  = 0;
    int next_gap     = 0;
    bit req_held     = 1'b0;
    bit send_idle_on = 1'b0;
    bit rsp_idle_on  = 1'b0;
    int rsp_hold     = 0;

    least_loaded_dispatcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic req_t make_req(logic cmd, logic [WORKER_W-1:0] worker);
        req_t r;
        r.cmd    = cmd;
        r.worker = worker;
        return r;
    endfunction

    // assign or done at even odds, mostly for workers in the selection, some for any index
    function automatic req_t random_request();
        req_t r;
        int   n;
        n = tracker.active_workers();
        r.cmd = ($urandom_range(0, 1) == 0) ? CMD_ASSIGN : CMD_DONE;
        if ($urandom_range(0, 4) == 0)
            r.worker = WORKER_W'($urandom_range(0, 15));
        else
            r.worker = WORKER_W'($urandom_range(0, n - 1));
        return r;
    endfunction

    // offer one item; valid stays high into the next item when no gap follows
    task automatic send_request(input req_t item);
        repeat (next_gap) @(posedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        tracker.note_request(item);
        next_gap = send_idle_on ? $urandom_range(0, 9) : 0;
        if (next_gap > 0)
            req_valid <= 1'b0;
        req_held = (next_gap == 0);
    endtask

    task automatic release_req();
        if (req_held)
        begin
            req_valid <= 1'b0;
            req_held = 1'b0;
        end
    endtask

    task automatic wait_idle();
        while (tracker.pending_count() != 0)
            @(posedge clk);
    endtask

    // register write, only with nothing in flight
    task automatic write_workers(input logic [CFG_W-1:0] value);
        release_req();
        wait_idle();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_workers(value);
    endtask

    // response side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rsp_hold > 0)
            begin
                stall = rsp_hold;
                rsp_hold = 0;
            end
            else
            begin
                stall = rsp_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            tracker.check_response(rsp);
        end
    end

    // stimulus
    initial
    begin
        logic [CFG_W-1:0] setting;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting, ties, negative counts
        send_request(make_req(CMD_ASSIGN, 4'd0));
        send_request(make_req(CMD_ASSIGN, 4'd15));
        send_request(make_req(CMD_DONE, 4'd15));
        send_request(make_req(CMD_DONE, 4'd0));
        send_request(make_req(CMD_ASSIGN, 4'd7));
        send_request(make_req(CMD_DONE, 4'd14));

        // zero workers acts as one
        write_workers(5'd0);
        send_request(make_req(CMD_DONE, 4'd1));
        send_request(make_req(CMD_DONE, 4'd15));
        send_request(make_req(CMD_ASSIGN, 4'd9));
        send_request(make_req(CMD_DONE, 4'd0));

        // above the array size clips to sixteen
        write_workers(5'd31);
        send_request(make_req(CMD_ASSIGN, 4'd0));
        send_request(make_req(CMD_DONE, 4'd15));
        write_workers(5'd17);
        send_request(make_req(CMD_DONE, 4'd15));
        send_request(make_req(CMD_ASSIGN, 4'd3));

        // range edge of a partial selection
        write_workers(5'd5);
        send_request(make_req(CMD_DONE, 4'd5));
        send_request(make_req(CMD_DONE, 4'd4));
        send_request(make_req(CMD_ASSIGN, 4'd12));
        write_workers(5'd1);
        send_request(make_req(CMD_ASSIGN, 4'd0));

        // random phases over several settings
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       setting = 5'd1;
                1:       setting = 5'd16;
                2:       setting = 5'd0;
                3:       setting = 5'd31;
                default: setting = CFG_W'($urandom_range(0, 31));
            endcase
            write_workers(setting);
            send_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on  = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // back-to-back items against a long response hold-off
                if (p == 1 && i == 0)
                begin
                    send_idle_on = 1'b0;
                    rsp_hold = HOLD_CYCLES;
                end
                if (p == 1 && i == 30)
                    send_idle_on = 1'b1;
                send_request(random_request());
            end
        end

        // a few items on a two-worker selection
        write_workers(5'd2);
        send_idle_on = 1'b0;
        rsp_idle_on  = 1'b0;
        send_request(make_req(CMD_DONE, 4'd1));
        send_request(make_req(CMD_DONE, 4'd0));
        send_request(make_req(CMD_ASSIGN, 4'd15));
        send_request(make_req(CMD_DONE, 4'd2));

        // drain and finish
        release_req();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.check_leftover();
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
